// ===== hw/rtl/flsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Free-list slot allocator package
// Shared widths, request and status codes, and transfer types.
// ----------------------------------------------------------------------------
package flsa_pkg;

  localparam int unsigned SlotsDef = 32;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned StatusW  = 2;

  localparam logic [ReqW-1:0] REQ_ALLOC   = 2'd0;
  localparam logic [ReqW-1:0] REQ_RELEASE = 2'd1;
  localparam logic [ReqW-1:0] REQ_LOOKUP  = 2'd2;

  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY    = 2'd1;
  localparam logic [StatusW-1:0] ST_NOT_USED = 2'd2;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [SlotW-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [SlotW-1:0]   result_slot;
    logic [StatusW-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } rsp_evt_t;

endpackage

// ===== hw/rtl/flsa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module flsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/flsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Free-list slot allocator controller
// Sequencer that walks and updates the link table held in the RAM.
// ----------------------------------------------------------------------------
module flsa_ctrl #(
  parameter int unsigned Slots = flsa_pkg::SlotsDef,
  localparam int unsigned IdxW  = $clog2(Slots),
  localparam int unsigned LinkW = $clog2(Slots + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  flsa_pkg::req_t      req_i,
  output logic                busy_o,
  output flsa_pkg::rsp_evt_t  evt_o,
  output logic                wr_en_o,
  output logic [IdxW-1:0]     wr_addr_o,
  output logic [LinkW:0]      wr_data_o,
  output logic                rd_en_o,
  output logic [IdxW-1:0]     rd_addr_o,
  input  logic [LinkW:0]      rd_data_i
);

  localparam int unsigned CmpW = (flsa_pkg::SlotW > LinkW) ? flsa_pkg::SlotW : LinkW;
  localparam logic [LinkW-1:0] NoneLink = LinkW'(Slots);
  localparam logic [LinkW-1:0] LastIdx  = LinkW'(Slots - 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_A_HEAD = 3'd2;
  localparam logic [2:0] S_A_WALK = 3'd3;
  localparam logic [2:0] S_R_CHK  = 3'd4;
  localparam logic [2:0] S_R_WALK = 3'd5;
  localparam logic [2:0] S_R_FIN  = 3'd6;
  localparam logic [2:0] S_L_CHK  = 3'd7;

  typedef struct packed {
    logic             used;
    logic [LinkW-1:0] link;
  } entry_t;

  logic [2:0]                   state_q, state_d;
  logic [LinkW-1:0]             cnt_q, cnt_d;
  logic [LinkW-1:0]             free_head_q, free_head_d;
  logic [LinkW-1:0]             used_head_q, used_head_d;
  logic [LinkW-1:0]             cur_q, cur_d;
  logic [LinkW-1:0]             snext_q, snext_d;
  logic [LinkW-1:0]             alloc_q, alloc_d;
  logic [flsa_pkg::SlotW-1:0]   slot_q, slot_d;

  entry_t           rd_entry;
  entry_t           wr_entry;
  logic             in_range;
  logic [IdxW-1:0]  req_idx;
  logic [LinkW-1:0] slot_link;

  assign rd_entry  = entry_t'(rd_data_i);
  assign wr_data_o = wr_entry;
  assign in_range  = CmpW'(req_i.slot) < CmpW'(Slots);
  assign req_idx   = IdxW'(req_i.slot);
  assign slot_link = LinkW'(slot_q);
  assign busy_o    = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    free_head_d = free_head_q;
    used_head_d = used_head_q;
    cur_d       = cur_q;
    snext_d     = snext_q;
    alloc_d     = alloc_q;
    slot_d      = slot_q;
    evt_o       = '0;
    wr_en_o     = 1'b0;
    wr_addr_o   = '0;
    wr_entry    = '0;
    rd_en_o     = 1'b0;
    rd_addr_o   = '0;

    unique case (state_q)
      S_INIT: begin
        wr_en_o       = 1'b1;
        wr_addr_o     = IdxW'(cnt_q);
        wr_entry.used = 1'b0;
        wr_entry.link = cnt_q + LinkW'(1);
        cnt_d         = cnt_q + LinkW'(1);
        if (cnt_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          slot_d = req_i.slot;
          unique case (req_i.req_type)
            flsa_pkg::REQ_ALLOC: begin
              if (free_head_q == NoneLink) begin
                evt_o.valid           = 1'b1;
                evt_o.rsp.result_slot = '0;
                evt_o.rsp.status      = flsa_pkg::ST_EMPTY;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = IdxW'(free_head_q);
                alloc_d   = free_head_q;
                state_d   = S_A_HEAD;
              end
            end
            flsa_pkg::REQ_RELEASE: begin
              if (!in_range) begin
                evt_o.valid           = 1'b1;
                evt_o.rsp.result_slot = req_i.slot;
                evt_o.rsp.status      = flsa_pkg::ST_NOT_USED;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = req_idx;
                state_d   = S_R_CHK;
              end
            end
            default: begin
              if (!in_range) begin
                evt_o.valid           = 1'b1;
                evt_o.rsp.result_slot = req_i.slot;
                evt_o.rsp.status      = flsa_pkg::ST_NOT_USED;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = req_idx;
                state_d   = S_L_CHK;
              end
            end
          endcase
        end
      end
      S_A_HEAD: begin
        free_head_d   = rd_entry.link;
        wr_en_o       = 1'b1;
        wr_addr_o     = IdxW'(alloc_q);
        wr_entry.used = 1'b1;
        wr_entry.link = NoneLink;
        if (used_head_q >= NoneLink) begin
          used_head_d           = alloc_q;
          evt_o.valid           = 1'b1;
          evt_o.rsp.result_slot = flsa_pkg::SlotW'(alloc_q);
          evt_o.rsp.status      = flsa_pkg::ST_OK;
          state_d               = S_IDLE;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = IdxW'(used_head_q);
          cur_d     = used_head_q;
          state_d   = S_A_WALK;
        end
      end
      S_A_WALK: begin
        if (rd_entry.link >= NoneLink) begin
          wr_en_o               = 1'b1;
          wr_addr_o             = IdxW'(cur_q);
          wr_entry.used         = 1'b1;
          wr_entry.link         = alloc_q;
          evt_o.valid           = 1'b1;
          evt_o.rsp.result_slot = flsa_pkg::SlotW'(alloc_q);
          evt_o.rsp.status      = flsa_pkg::ST_OK;
          state_d               = S_IDLE;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = IdxW'(rd_entry.link);
          cur_d     = rd_entry.link;
        end
      end
      S_R_CHK: begin
        if (!rd_entry.used) begin
          evt_o.valid           = 1'b1;
          evt_o.rsp.result_slot = slot_q;
          evt_o.rsp.status      = flsa_pkg::ST_NOT_USED;
          state_d               = S_IDLE;
        end else begin
          snext_d = rd_entry.link;
          if (used_head_q == slot_link) begin
            used_head_d = rd_entry.link;
            state_d     = S_R_FIN;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = IdxW'(used_head_q);
            cur_d     = used_head_q;
            state_d   = S_R_WALK;
          end
        end
      end
      S_R_WALK: begin
        if (rd_entry.link == slot_link) begin
          wr_en_o       = 1'b1;
          wr_addr_o     = IdxW'(cur_q);
          wr_entry.used = 1'b1;
          wr_entry.link = snext_q;
          state_d       = S_R_FIN;
        end else if (rd_entry.link >= NoneLink) begin
          state_d = S_R_FIN;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = IdxW'(rd_entry.link);
          cur_d     = rd_entry.link;
        end
      end
      S_R_FIN: begin
        wr_en_o               = 1'b1;
        wr_addr_o             = IdxW'(slot_q);
        wr_entry.used         = 1'b0;
        wr_entry.link         = free_head_q;
        free_head_d           = slot_link;
        evt_o.valid           = 1'b1;
        evt_o.rsp.result_slot = slot_q;
        evt_o.rsp.status      = flsa_pkg::ST_OK;
        state_d               = S_IDLE;
      end
      S_L_CHK: begin
        evt_o.valid           = 1'b1;
        evt_o.rsp.result_slot = slot_q;
        evt_o.rsp.status      = rd_entry.used ? flsa_pkg::ST_OK : flsa_pkg::ST_NOT_USED;
        state_d               = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      free_head_q <= '0;
      used_head_q <= NoneLink;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      free_head_q <= free_head_d;
      used_head_q <= used_head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    snext_q <= snext_d;
    alloc_q <= alloc_d;
    slot_q  <= slot_d;
  end

  a_evt_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.valid |-> state_d == S_IDLE)
    else $error("result transfer without return to idle");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_o && rd_en_o) |-> wr_addr_o != rd_addr_o)
    else $error("read and write of the same entry in one cycle");

  a_walk_on_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_WALK || state_q == S_R_WALK) |-> cur_q < NoneLink)
    else $error("list walk on an empty link");

  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !evt_o.valid && !rd_en_o)
    else $error("activity during table initialization");

endmodule

// ===== hw/rtl/free_list_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Free-list slot allocator unit
// Allocates, releases and looks up slots of a fixed pool kept in a link table.
// ----------------------------------------------------------------------------
// After reset the unit writes every entry of the link table and holds busy
// high meanwhile. A request is taken when start is high and busy is low,
// and exactly one result follows with done_o high for one cycle; the result
// must be taken in that cycle. Allocate walks to the end of the in-use list
// and release walks that list to find the slot's predecessor, both at one
// RAM read per cycle.
module free_list_slot_allocator_unit #(
  parameter int unsigned Slots = flsa_pkg::SlotsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  flsa_pkg::req_t req_i,
  output logic           busy,
  output logic           done_o,
  output flsa_pkg::rsp_t rsp_o
);

  localparam int unsigned IdxW  = $clog2(Slots);
  localparam int unsigned LinkW = $clog2(Slots + 1);

  flsa_pkg::rsp_evt_t evt;
  logic               wr_en;
  logic [IdxW-1:0]    wr_addr;
  logic [LinkW:0]     wr_data;
  logic               rd_en;
  logic [IdxW-1:0]    rd_addr;
  logic [LinkW:0]     rd_data;
  logic               done_q;
  flsa_pkg::rsp_t     rsp_q;

  flsa_ctrl #(
    .Slots(Slots)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .req_i    (req_i),
    .busy_o   (busy),
    .evt_o    (evt),
    .wr_en_o  (wr_en),
    .wr_addr_o(wr_addr),
    .wr_data_o(wr_data),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data)
  );

  flsa_ram #(
    .Width(LinkW + 1),
    .Depth(Slots)
  ) u_link_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= evt.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt.valid) begin
      rsp_q <= evt.rsp;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== tb/free_list_slot_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Free-list slot allocator unit testbench
// Drives allocate, release and lookup requests through the start/busy command
// port and checks every done_o response against the directed table or an
// in-bench model of the free and in-use lists. A short directed table comes
// first, then random request streams swing the pool between full and empty.
// ----------------------------------------------------------------------------
module free_list_slot_allocator_unit_tb;

  localparam int unsigned SLOTS = flsa_pkg::SlotsDef;
  localparam int unsigned LinkW = $clog2(SLOTS + 1);
  localparam int unsigned IdxW  = $clog2(SLOTS);
  localparam logic [LinkW-1:0] NO_LINK = LinkW'(SLOTS);
  localparam logic [flsa_pkg::ReqW-1:0] REQ_SPARE = 2'd3;
  localparam int RAND_ITEMS = 1550;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 16;
  localparam int NDIR = 24;

  typedef struct packed {
    flsa_pkg::req_t req;
    logic [7:0]     reps;
    logic           chk;
    flsa_pkg::rsp_t rsp;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [0:NDIR-1] = '{
    '{'{flsa_pkg::REQ_LOOKUP,  5'd0},  8'd1,  1'b1, '{5'd0,  flsa_pkg::ST_NOT_USED}},
    '{'{flsa_pkg::REQ_LOOKUP,  5'd31}, 8'd1,  1'b1, '{5'd31, flsa_pkg::ST_NOT_USED}},
    '{'{flsa_pkg::REQ_RELEASE, 5'd31}, 8'd1,  1'b1, '{5'd31, flsa_pkg::ST_NOT_USED}},
    '{'{REQ_SPARE,             5'd0},  8'd1,  1'b1, '{5'd0,  flsa_pkg::ST_NOT_USED}},
    '{'{flsa_pkg::REQ_ALLOC,   5'd31}, 8'd1,  1'b1, '{5'd0,  flsa_pkg::ST_OK}},
    '{'{flsa_pkg::REQ_ALLOC,   5'd0},  8'd1,  1'b1, '{5'd1,  flsa_pkg::ST_OK}},
    '{'{flsa_pkg::REQ_ALLOC,   5'd0},  8'd1,  1'b1, '{5'd2,  flsa_pkg::ST_OK}},
    '{'{flsa_pkg::REQ_LOOKUP,  5'd1},  8'd1,  1'b1, '{5'd1,  flsa_pkg::ST_OK}},
    '{'{flsa_pkg::REQ_RELEASE, 5'd1},  8'd1,  1'b1, '{5'd1,  flsa_pkg::ST_OK}},
    '{'{flsa_pkg::REQ_LOOKUP,  5'd1},  8'd1,  1'b1, '{5'd1,  flsa_pkg::ST_NOT_USED}},
    '{'{flsa_pkg::REQ_ALLOC,   5'd0},  8'd1,  1'b1, '{5'd1,  flsa_pkg::ST_OK}},
    '{'{flsa_pkg::REQ_RELEASE, 5'd0},  8'd1,  1'b1, '{5'd0,  flsa_pkg::ST_OK}},
    '{'{flsa_pkg::REQ_RELEASE, 5'd1},  8'd1,  1'b1, '{5'd1,  flsa_pkg::ST_OK}},
    '{'{flsa_pkg::REQ_RELEASE, 5'd1},  8'd1,  1'b1, '{5'd1,  flsa_pkg::ST_NOT_USED}},
    '{'{REQ_SPARE,             5'd2},  8'd1,  1'b1, '{5'd2,  flsa_pkg::ST_OK}},
    '{'{flsa_pkg::REQ_ALLOC,   5'd0},  8'd31, 1'b0, '{5'd0,  flsa_pkg::ST_OK}},
    '{'{flsa_pkg::REQ_ALLOC,   5'd0},  8'd1,  1'b1, '{5'd0,  flsa_pkg::ST_EMPTY}},
    '{'{flsa_pkg::REQ_ALLOC,   5'd31}, 8'd1,  1'b1, '{5'd0,  flsa_pkg::ST_EMPTY}},
    '{'{flsa_pkg::REQ_RELEASE, 5'd31}, 8'd1,  1'b1, '{5'd31, flsa_pkg::ST_OK}},
    '{'{flsa_pkg::REQ_ALLOC,   5'd21}, 8'd1,  1'b1, '{5'd31, flsa_pkg::ST_OK}},
    '{'{flsa_pkg::REQ_RELEASE, 5'd2},  8'd1,  1'b0, '{5'd0,  flsa_pkg::ST_OK}},
    '{'{flsa_pkg::REQ_LOOKUP,  5'd2},  8'd1,  1'b1, '{5'd2,  flsa_pkg::ST_NOT_USED}},
    '{'{flsa_pkg::REQ_RELEASE, 5'd15}, 8'd1,  1'b0, '{5'd0,  flsa_pkg::ST_OK}},
    '{'{flsa_pkg::REQ_ALLOC,   5'd0},  8'd1,  1'b0, '{5'd0,  flsa_pkg::ST_OK}}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  flsa_pkg::req_t req_i = '0;
  logic busy;
  logic done_o;
  flsa_pkg::rsp_t rsp_o;

  logic [LinkW-1:0] nxt_link [SLOTS];
  logic [LinkW-1:0] free_top;
  logic [LinkW-1:0] used_first;
  logic             slot_taken [SLOTS];

  flsa_pkg::rsp_t resp_expect_q [$];
  flsa_pkg::req_t cur_req;
  logic cur_has_exp;
  flsa_pkg::rsp_t cur_exp;
  logic have_item = 1'b0;
  logic stim_done = 1'b0;
  int   dir_idx = 0;
  int   dir_rep = 0;
  int   rand_cnt = 0;
  int   err_cnt = 0;
  int   stall_cycles = 0;

  free_list_slot_allocator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  function automatic flsa_pkg::rsp_t predict_response(input flsa_pkg::req_t r);
    flsa_pkg::rsp_t   o;
    logic [LinkW-1:0] s;
    logic [LinkW-1:0] cur;
    logic             hit;
    o.result_slot = r.slot;
    o.status = flsa_pkg::ST_OK;
    s = LinkW'(r.slot);
    case (r.req_type)
      flsa_pkg::REQ_ALLOC: begin
        if (free_top == NO_LINK) begin
          o.result_slot = '0;
          o.status = flsa_pkg::ST_EMPTY;
        end else begin
          s = free_top;
          free_top = nxt_link[s[IdxW-1:0]];
          nxt_link[s[IdxW-1:0]] = NO_LINK;
          slot_taken[s[IdxW-1:0]] = 1'b1;
          if (used_first == NO_LINK) begin
            used_first = s;
          end else begin
            cur = used_first;
            for (int n = 0; n < SLOTS && nxt_link[cur[IdxW-1:0]] != NO_LINK; n++) begin
              cur = nxt_link[cur[IdxW-1:0]];
            end
            nxt_link[cur[IdxW-1:0]] = s;
          end
          o.result_slot = s[flsa_pkg::SlotW-1:0];
        end
      end
      flsa_pkg::REQ_RELEASE: begin
        if (s >= SLOTS || !slot_taken[s[IdxW-1:0]]) begin
          o.status = flsa_pkg::ST_NOT_USED;
        end else begin
          if (used_first == s) begin
            used_first = nxt_link[s[IdxW-1:0]];
          end else begin
            cur = used_first;
            hit = 1'b0;
            for (int n = 0; n < SLOTS && cur < SLOTS && !hit; n++) begin
              if (nxt_link[cur[IdxW-1:0]] == s) begin
                nxt_link[cur[IdxW-1:0]] = nxt_link[s[IdxW-1:0]];
                hit = 1'b1;
              end else begin
                cur = nxt_link[cur[IdxW-1:0]];
              end
            end
          end
          nxt_link[s[IdxW-1:0]] = free_top;
          free_top = s;
          slot_taken[s[IdxW-1:0]] = 1'b0;
        end
      end
      default: begin
        if (s >= SLOTS || !slot_taken[s[IdxW-1:0]]) o.status = flsa_pkg::ST_NOT_USED;
      end
    endcase
    return o;
  endfunction

  function automatic flsa_pkg::req_t random_request();
    flsa_pkg::req_t r;
    int unsigned    alloc_pct;
    int             n_used;
    int             pick;
    r = flsa_pkg::req_t'($urandom);
    case ((rand_cnt / 150) % 3)
      0: alloc_pct = 65;
      1: alloc_pct = 20;
      default: alloc_pct = 45;
    endcase
    n_used = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_taken[i]) n_used++;
    end
    if ($urandom_range(99) < 15) begin
      return r;
    end
    if ($urandom_range(99) < alloc_pct || n_used == 0) begin
      r.req_type = flsa_pkg::REQ_ALLOC;
    end else begin
      r.req_type = flsa_pkg::REQ_RELEASE;
      pick = $urandom_range(n_used - 1);
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_taken[i]) begin
          if (pick == 0) r.slot = flsa_pkg::SlotW'(i);
          pick--;
        end
      end
    end
    return r;
  endfunction

  task automatic load_next_item();
    dir_row_t row;
    if (dir_idx < NDIR) begin
      row = DIR_TAB[dir_idx];
      cur_req = row.req;
      cur_has_exp = row.chk;
      cur_exp = row.rsp;
      have_item = 1'b1;
      dir_rep++;
      if (dir_rep >= row.reps) begin
        dir_idx++;
        dir_rep = 0;
      end
    end else if (rand_cnt < RAND_ITEMS) begin
      cur_req = random_request();
      cur_has_exp = 1'b0;
      have_item = 1'b1;
      rand_cnt++;
    end else begin
      stim_done = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin : drive_and_check
    flsa_pkg::rsp_t want;
    flsa_pkg::rsp_t pred;
    logic took;
    logic start_nxt;
    if (rst_ni) begin
      if (done_o) begin
        if (resp_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected response slot %0d status %0d",
                                    rsp_o.result_slot, rsp_o.status));
        end else begin
          want = resp_expect_q.pop_front();
          if (rsp_o.result_slot !== want.result_slot) begin
            report_mismatch($sformatf("result_slot got %0d want %0d",
                                      rsp_o.result_slot, want.result_slot));
          end
          if (rsp_o.status !== want.status) begin
            report_mismatch($sformatf("status got %0d want %0d (slot %0d)",
                                      rsp_o.status, want.status, want.result_slot));
          end
        end
      end
      took = start && !busy;
      if (took) begin
        pred = predict_response(cur_req);
        resp_expect_q.push_back(cur_has_exp ? cur_exp : pred);
        have_item = 1'b0;
      end
      if (!have_item && !stim_done) load_next_item();
      if (start && !took) begin
        start_nxt = 1'b1;
      end else begin
        start_nxt = have_item &&
                    ((rand_cnt >= 500 && rand_cnt < 800) || $urandom_range(99) >= 29);
      end
      start <= start_nxt;
      req_i <= start_nxt ? cur_req : flsa_pkg::req_t'($urandom);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[free_list_slot_allocator_unit] ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      nxt_link[i] = LinkW'(i + 1);
      slot_taken[i] = 1'b0;
    end
    free_top = '0;
    used_first = NO_LINK;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(stim_done && resp_expect_q.size() == 0)) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[free_list_slot_allocator_unit] OK");
    end else begin
      $display("[free_list_slot_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule
